// ===== rtl/stoc_pkg.sv =====
// Package for the sine table oscillator: opcodes, field widths, CORDIC angles,
// controller states and the command/status structs. No dependencies.
package stoc_pkg;

  localparam int unsigned OPC_W        = 2;
  localparam int unsigned FREQ_W       = 17;
  localparam int unsigned SR_W         = 18;
  localparam int unsigned AMP_W        = 15;
  localparam int unsigned SMP_W        = 16;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 18;
  localparam int unsigned DIV_W        = 18;
  localparam int unsigned DIV_CNT_W    = 5;
  localparam int unsigned PH_W         = 16;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CORDIC_CNT_W = 4;
  localparam int unsigned XY_W         = 34;
  localparam int unsigned Z_W          = 32;
  localparam int unsigned PROD_W       = XY_W + AMP_W + 1;

  typedef enum logic [OPC_W-1:0] {
    OP_TICK    = 2'd0,
    OP_RETUNE  = 2'd1,
    OP_RESTART = 2'd2,
    OP_NONE    = 2'd3
  } opcode_e;

  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE   = 2'd1;

  localparam logic [SR_W-1:0]  SR_RESET  = 18'd48000;
  localparam logic [AMP_W-1:0] AMP_RESET = 15'd16384;

  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032865;
  localparam logic [DIV_W-1:0]       RECIP_NUM = 18'd65536;

  function automatic logic signed [Z_W-1:0] step_angle(input logic [CORDIC_CNT_W-1:0] k);
    logic signed [Z_W-1:0] a;
    unique case (k)
      4'd0:  a = 32'sd134217728;
      4'd1:  a = 32'sd79233351;
      4'd2:  a = 32'sd41864727;
      4'd3:  a = 32'sd21251189;
      4'd4:  a = 32'sd10666832;
      4'd5:  a = 32'sd5338616;
      4'd6:  a = 32'sd2669960;
      4'd7:  a = 32'sd1335061;
      4'd8:  a = 32'sd667541;
      4'd9:  a = 32'sd333772;
      4'd10: a = 32'sd166886;
      4'd11: a = 32'sd83443;
      4'd12: a = 32'sd41722;
      4'd13: a = 32'sd20861;
      4'd14: a = 32'sd10430;
      4'd15: a = 32'sd5215;
    endcase
    return a;
  endfunction

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_PREP    = 10'b0000000010,
    S_DIV_P   = 10'b0000000100,
    S_DIV_R   = 10'b0000001000,
    S_LOAD    = 10'b0000010000,
    S_CORDIC  = 10'b0000100000,
    S_MUL     = 10'b0001000000,
    S_WR      = 10'b0010000000,
    S_SCAN_RD = 10'b0100000000,
    S_SCAN_EV = 10'b1000000000
  } state_e;

  typedef struct packed {
    logic tick;
    logic freq_load;
    logic cap_rd;
    logic cap_latch;
    logic div_p_start;
    logic period_load;
    logic div_r_start;
    logic fill_init;
    logic cordic_load;
    logic cordic_step;
    logic mul;
    logic wr_entry;
    logic scan_rd;
    logic scan_eval;
  } cmd_t;

  typedef struct packed {
    logic tick_ok;
    logic has_table;
    logic div_done;
    logic cordic_last;
    logic fill_last;
  } sts_t;

endpackage

// ===== rtl/stoc_if.sv =====
// Channel interfaces: item input, sample output and configuration write.
// Depends on stoc_pkg.
interface stoc_in_if;
  logic                            valid;
  logic                            ready;
  logic [stoc_pkg::OPC_W-1:0]      opcode;
  logic [stoc_pkg::FREQ_W-1:0]     new_frequency;
  modport source (output valid, output opcode, output new_frequency, input ready);
  modport sink   (input valid, input opcode, input new_frequency, output ready);
endinterface

interface stoc_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [stoc_pkg::SMP_W-1:0] sample_out;
  modport source (output valid, output sample_out, input ready);
  modport sink   (input valid, input sample_out, output ready);
endinterface

interface stoc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [stoc_pkg::CFG_IDX_W-1:0]  index;
  logic [stoc_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/sine_table_oscillator_retune.sv =====
// Sine table oscillator top level. Ticks: one per cycle while no rebuild runs and the
// output is not stalled; each sample passes the registered table read, then the output register.
// Retune/restart: a setup state, two divides (period, then reciprocal), then per table
// entry a 16-step CORDIC, multiply and write, and for a retune a scan over the entries.
// Reset: no table, position 0, ticks give 0; sample_rate 48000, amplitude 16384.
module sine_table_oscillator_retune #(
  parameter int unsigned MAX_PERIOD = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  stoc_in_if.sink      in_i,
  stoc_out_if.source   out_o,
  stoc_cfg_if.sink     cfg_i
);
  import stoc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  stoc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .opcode_i   (in_i.opcode),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stoc_dpath #(.MAX_PERIOD(MAX_PERIOD)) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .freq_i       (in_i.new_frequency),
    .cfg_we_i     (cfg_i.valid),
    .cfg_idx_i    (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_sample_o (out_o.sample_out)
  );
endmodule

// ===== rtl/stoc_div.sv =====
// Restoring divider, one quotient bit per cycle, unsigned.
// Depends on stoc_pkg.
module stoc_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [stoc_pkg::DIV_W-1:0] dividend_i,
  input  logic [stoc_pkg::DIV_W-1:0] divisor_i,
  output logic                       done_o,
  output logic [stoc_pkg::DIV_W-1:0] quot_o,
  output logic [stoc_pkg::DIV_W-1:0] rem_o
);
  import stoc_pkg::*;

  logic                 busy_q, done_q;
  logic [DIV_CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0]     rem_q, quo_q, dsr_q;
  logic [DIV_W:0]       shifted;
  logic [DIV_W+1:0]     diff;
  logic                 fits;

  assign shifted = {rem_q, quo_q[DIV_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_q};
  assign fits    = !diff[DIV_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : shifted[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;
endmodule

// ===== rtl/stoc_dpath.sv =====
// Datapath: config registers, wave table memory, tick read stage and output
// register, period divider, incremental phase, CORDIC, scaling and slope scan.
// Depends on stoc_pkg and stoc_div.
module stoc_dpath #(
  parameter int unsigned MAX_PERIOD = 4096
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  stoc_pkg::cmd_t                   cmd_i,
  output stoc_pkg::sts_t                   sts_o,
  input  logic [stoc_pkg::FREQ_W-1:0]      freq_i,
  input  logic                             cfg_we_i,
  input  logic [stoc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [stoc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic signed [stoc_pkg::SMP_W-1:0] out_sample_o
);
  import stoc_pkg::*;

  localparam int unsigned AW = $clog2(MAX_PERIOD);
  localparam int unsigned PW = $clog2(MAX_PERIOD + 1);
  localparam logic signed [PROD_W-1:0] RND     = PROD_W'(1) <<< 29;
  localparam logic signed [PROD_W-1:0] SAT_HI  = PROD_W'(32767);
  localparam logic signed [PROD_W-1:0] SAT_LO  = -PROD_W'(32768);

  logic [SR_W-1:0]   sr_q;
  logic [AMP_W-1:0]  amp_q;
  logic [FREQ_W-1:0] freq_q;
  logic [PW-1:0]     period_q;
  logic [AW-1:0]     pos_q, idx_q;
  logic [PH_W-1:0]   p_q, q0_q;
  logic [DIV_W-1:0]  r_q, r0_q;
  logic signed [SMP_W-1:0] cur_q;
  logic              rising_q, found_q;
  logic signed [SMP_W:0] best_q;
  logic signed [XY_W-1:0] x_q, y_q;
  logic signed [Z_W-1:0]  z_q;
  logic [CORDIC_CNT_W-1:0] k_q;
  logic              neg_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [SMP_W-1:0]  mem [MAX_PERIOD];
  logic signed [SMP_W-1:0] rd_a_q, rd_b_q;
  logic              rd_valid_q, rd_zero_q, out_valid_q;
  logic signed [SMP_W-1:0] out_q;

  logic              has_table, move, re_a, re_b, idx_last;
  logic [AW-1:0]     addr_a, addr_b;
  logic [PW-1:0]     addr_a_inc, idx_inc;
  logic              div_start, div_done;
  logic [DIV_W-1:0]  div_num, div_den, div_quo, div_rem;
  logic [DIV_W-1:0]  period_sat;
  logic signed [PH_W-1:0] fold_a;
  logic              fold_neg;
  logic signed [XY_W-1:0] xs, ys;
  logic signed [Z_W-1:0]  ang;
  logic signed [PROD_W-1:0] v, vn;
  logic signed [SMP_W-1:0] entry;
  logic [DIV_W:0]    rs;
  logic signed [SMP_W:0] d;
  logic              slope_ok;

  assign has_table  = (period_q != '0);
  assign move       = rd_valid_q && (!out_valid_q || out_ready_i);
  assign addr_a     = cmd_i.scan_rd ? idx_q : pos_q;
  assign addr_a_inc = PW'(addr_a) + 1'b1;
  assign addr_b     = (addr_a_inc == period_q) ? '0 : addr_a_inc[AW-1:0];
  assign re_a       = (cmd_i.tick && has_table) || cmd_i.cap_rd || cmd_i.scan_rd;
  assign re_b       = cmd_i.cap_rd || cmd_i.scan_rd;
  assign idx_inc    = PW'(idx_q) + 1'b1;
  assign idx_last   = (idx_inc == period_q);

  assign sts_o.tick_ok     = !rd_valid_q || !out_valid_q || out_ready_i;
  assign sts_o.has_table   = has_table;
  assign sts_o.div_done    = div_done;
  assign sts_o.cordic_last = (k_q == CORDIC_CNT_W'(CORDIC_STEPS - 1));
  assign sts_o.fill_last   = idx_last;

  assign div_start = cmd_i.div_p_start || cmd_i.div_r_start;
  assign div_num   = cmd_i.div_p_start ? sr_q : RECIP_NUM;
  assign div_den   = cmd_i.div_p_start ? {1'b0, freq_q} : period_sat;

  always_comb begin
    if (freq_q == '0) begin
      period_sat = DIV_W'(MAX_PERIOD);
    end else if (div_quo < DIV_W'(2)) begin
      period_sat = DIV_W'(2);
    end else if (div_quo > DIV_W'(MAX_PERIOD)) begin
      period_sat = DIV_W'(MAX_PERIOD);
    end else begin
      period_sat = div_quo;
    end
  end

  stoc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_num),
    .divisor_i  (div_den),
    .done_o     (div_done),
    .quot_o     (div_quo),
    .rem_o      (div_rem)
  );

  always_comb begin
    fold_neg = 1'b0;
    if (p_q >= PH_W'(16384) && p_q < PH_W'(49152)) begin
      fold_a   = $signed(p_q - PH_W'(32768));
      fold_neg = 1'b1;
    end else begin
      fold_a = $signed(p_q);
    end
  end

  assign xs  = x_q >>> k_q;
  assign ys  = y_q >>> k_q;
  assign ang = step_angle(k_q);

  always_comb begin
    v = (prod_q + RND) >>> 30;
    vn = neg_q ? -v : v;
    if (vn > SAT_HI) begin
      entry = 16'sh7fff;
    end else if (vn < SAT_LO) begin
      entry = -16'sh8000;
    end else begin
      entry = vn[SMP_W-1:0];
    end
  end

  assign rs = {1'b0, r_q} + {1'b0, r0_q};
  assign d  = rising_q ? (SMP_W+1)'(rd_a_q) - (SMP_W+1)'(cur_q)
                       : (SMP_W+1)'(cur_q) - (SMP_W+1)'(rd_a_q);
  assign slope_ok = rising_q ? (rd_a_q <= rd_b_q) : (rd_a_q >= rd_b_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q        <= SR_RESET;
      amp_q       <= AMP_RESET;
      period_q    <= '0;
      pos_q       <= '0;
      rd_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_idx_i == CFG_SAMPLE_RATE) begin
        sr_q <= cfg_data_i[SR_W-1:0];
      end
      if (cfg_we_i && cfg_idx_i == CFG_AMPLITUDE) begin
        amp_q <= cfg_data_i[AMP_W-1:0];
      end
      if (cmd_i.tick) begin
        rd_valid_q <= 1'b1;
      end else if (move) begin
        rd_valid_q <= 1'b0;
      end
      if (move) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.period_load) begin
        period_q <= period_sat[PW-1:0];
      end
      if (cmd_i.tick && has_table) begin
        pos_q <= addr_b;
      end else if (cmd_i.fill_init) begin
        pos_q <= '0;
      end else if (cmd_i.scan_eval && d >= 0 && slope_ok && (!found_q || d < best_q)) begin
        pos_q <= idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick) begin
      rd_zero_q <= !has_table;
    end
    if (move) begin
      out_q <= rd_zero_q ? '0 : rd_a_q;
    end
    if (cmd_i.freq_load) begin
      freq_q <= freq_i;
    end
    if (cmd_i.cap_latch) begin
      cur_q    <= rd_a_q;
      rising_q <= (rd_a_q <= rd_b_q);
    end
    if (cmd_i.fill_init) begin
      idx_q   <= '0;
      p_q     <= '0;
      r_q     <= '0;
      q0_q    <= div_quo[PH_W-1:0];
      r0_q    <= div_rem;
      found_q <= 1'b0;
    end
    if (cmd_i.cordic_load) begin
      x_q   <= CORDIC_X0;
      y_q   <= '0;
      z_q   <= Z_W'(fold_a) <<< 14;
      k_q   <= '0;
      neg_q <= fold_neg;
    end else if (cmd_i.cordic_step) begin
      if (!z_q[Z_W-1]) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.mul) begin
      prod_q <= x_q * $signed({1'b0, amp_q});
    end
    if (cmd_i.wr_entry) begin
      idx_q <= idx_last ? '0 : idx_inc[AW-1:0];
      if (rs >= (DIV_W+1)'(period_q)) begin
        r_q <= DIV_W'(rs - (DIV_W+1)'(period_q));
        p_q <= p_q + q0_q + 1'b1;
      end else begin
        r_q <= rs[DIV_W-1:0];
        p_q <= p_q + q0_q;
      end
    end
    if (cmd_i.scan_eval) begin
      idx_q <= idx_last ? '0 : idx_inc[AW-1:0];
      if (d >= 0 && slope_ok && (!found_q || d < best_q)) begin
        found_q <= 1'b1;
        best_q  <= d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_entry) begin
      mem[idx_q] <= entry;
    end
    if (re_a) begin
      rd_a_q <= mem[addr_a];
    end
    if (re_b) begin
      rd_b_q <= mem[addr_b];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_q;
endmodule

// ===== rtl/stoc_ctrl.sv =====
// Controller: accepts items and sequences divide, fill, CORDIC and scan steps.
// Depends on stoc_pkg.
module stoc_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [stoc_pkg::OPC_W-1:0]  opcode_i,
  output logic                        in_ready_o,
  input  stoc_pkg::sts_t              sts_i,
  output stoc_pkg::cmd_t              cmd_o
);
  import stoc_pkg::*;

  state_e state_q, state_d;
  logic   scan_q, scan_d;
  logic   acc;

  assign acc = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = sts_i.tick_ok;
        if (acc) begin
          cmd_o.freq_load = 1'b1;
          unique case (opcode_e'(opcode_i))
            OP_TICK: cmd_o.tick = 1'b1;
            OP_RETUNE: begin
              cmd_o.cap_rd = sts_i.has_table;
              scan_d       = sts_i.has_table;
              state_d      = S_PREP;
            end
            OP_RESTART: begin
              scan_d  = 1'b0;
              state_d = S_PREP;
            end
            OP_NONE: ;
          endcase
        end
      end
      S_PREP: begin
        cmd_o.cap_latch   = 1'b1;
        cmd_o.div_p_start = 1'b1;
        state_d           = S_DIV_P;
      end
      S_DIV_P: begin
        if (sts_i.div_done) begin
          cmd_o.period_load = 1'b1;
          cmd_o.div_r_start = 1'b1;
          state_d           = S_DIV_R;
        end
      end
      S_DIV_R: begin
        if (sts_i.div_done) begin
          cmd_o.fill_init = 1'b1;
          state_d         = S_LOAD;
        end
      end
      S_LOAD: begin
        cmd_o.cordic_load = 1'b1;
        state_d           = S_CORDIC;
      end
      S_CORDIC: begin
        cmd_o.cordic_step = 1'b1;
        if (sts_i.cordic_last) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_WR;
      end
      S_WR: begin
        cmd_o.wr_entry = 1'b1;
        if (sts_i.fill_last) begin
          state_d = scan_q ? S_SCAN_RD : S_IDLE;
        end else begin
          state_d = S_LOAD;
        end
      end
      S_SCAN_RD: begin
        cmd_o.scan_rd = 1'b1;
        state_d       = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        cmd_o.scan_eval = 1'b1;
        if (sts_i.fill_last) begin
          scan_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      scan_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
    end
  end
endmodule

// ===== rtl/stoc_chk.sv =====
// Port-level checker for the sine table oscillator, bound to the top level.
// Depends on stoc_pkg.
module stoc_chk (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_ready_i,
  input logic [stoc_pkg::OPC_W-1:0] in_opcode_i,
  input logic                       out_valid_i,
  input logic                       out_ready_i,
  input logic [stoc_pkg::SMP_W-1:0] out_sample_i
);
  import stoc_pkg::*;

  logic acc;
  assign acc = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_sample_i))
    else $error("output beat dropped or changed while stalled");

  a_out_from_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(acc && in_opcode_i == OP_TICK, 2))
    else $error("output beat without a tick two cycles earlier");

  a_rebuild_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (in_opcode_i == OP_RETUNE || in_opcode_i == OP_RESTART) |=> !in_ready_i)
    else $error("input ready during table rebuild");
endmodule

bind sine_table_oscillator_retune stoc_chk u_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_opcode_i  (in_i.opcode),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_sample_i (out_o.sample_out)
);
